>>> rtl/hsten_pkg.sv
package hsten_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int TEMP_W      = 24;
  localparam int GWIDTH_W    = 11;
  localparam int GAIN_W      = 15;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 16;
  localparam int SUM_W       = TEMP_W + 3;
  localparam int PROD_W      = SUM_W + GAIN_W + 1;
  localparam int FRAC_SHIFT  = 16;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_SOURCE_COL  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SOURCE_ROW  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_GAIN        = IDX_W'(4);

  localparam logic [GWIDTH_W-1:0] RST_GRID_WIDTH  = GWIDTH_W'(10);
  localparam logic [ROW_W-1:0]    RST_GRID_HEIGHT = ROW_W'(10);
  localparam logic [COL_W-1:0]    RST_SOURCE_COL  = COL_W'(2);
  localparam logic [ROW_W-1:0]    RST_SOURCE_ROW  = ROW_W'(2);
  localparam logic [GAIN_W-1:0]   RST_GAIN        = GAIN_W'(6554);

  typedef struct packed {
    logic              shift;
    logic              emit;
    logic              last;
    logic              src;
    logic              left_edge;
    logic              right_edge;
    logic              top_edge;
    logic              bottom_edge;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  ecol;
    logic [ROW_W-1:0]  erow;
    logic [TEMP_W-1:0] temp;
  } tick_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [TEMP_W-1:0]       tc;
    logic                    src;
    logic [COL_W-1:0]        ecol;
    logic [ROW_W-1:0]        erow;
    logic                    last;
  } emit_t;

endpackage

>>> rtl/hsten_ram.sv
module hsten_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hsten_ctrl.sv
module hsten_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [hsten_pkg::IDX_W-1:0]      cfg_index,
  input  logic [hsten_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             accept,
  input  logic                             action,
  input  logic [hsten_pkg::TEMP_W-1:0]     cell_temp,
  output logic                             load,
  output hsten_pkg::tick_t                 tick,
  output logic [hsten_pkg::GAIN_W-1:0]     gain
);

  logic [hsten_pkg::GWIDTH_W-1:0] grid_width;
  logic [hsten_pkg::ROW_W-1:0]    grid_height;
  logic [hsten_pkg::COL_W-1:0]    source_col;
  logic [hsten_pkg::ROW_W-1:0]    source_row;

  logic [hsten_pkg::COL_W-1:0]    in_col;
  logic [hsten_pkg::ROW_W-1:0]    in_row;
  logic [hsten_pkg::COL_W-1:0]    emit_col;
  logic [hsten_pkg::ROW_W-1:0]    emit_row;

  logic [hsten_pkg::GWIDTH_W-1:0] w_eff;
  logic [hsten_pkg::ROW_W-1:0]    h_eff;
  logic                           complete;
  logic                           ignored;
  logic                           emit;
  logic                           col_end;
  logic                           ecol_end;
  logic                           erow_end;
  logic                           last;

  always_comb begin
    if (grid_width == '0) begin
      w_eff = hsten_pkg::GWIDTH_W'(1);
    end else if (grid_width > hsten_pkg::GWIDTH_W'(hsten_pkg::MAX_WIDTH)) begin
      w_eff = hsten_pkg::GWIDTH_W'(hsten_pkg::MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    h_eff = (grid_height == '0) ? hsten_pkg::ROW_W'(1) : grid_height;

    complete = (in_row >= h_eff);
    ignored  = !complete && action;
    emit     = (in_row >= hsten_pkg::ROW_W'(2)) ||
               ((in_row == hsten_pkg::ROW_W'(1)) && (in_col != '0));
    col_end  = ({1'b0, in_col} + hsten_pkg::GWIDTH_W'(1)) >= w_eff;
    ecol_end = ({1'b0, emit_col} + hsten_pkg::GWIDTH_W'(1)) >= w_eff;
    erow_end = ({1'b0, emit_row} + 17'd1) >= {1'b0, h_eff};
    last     = emit && erow_end && ecol_end;

    load             = accept && !ignored;
    tick.shift       = !last;
    tick.emit        = emit;
    tick.last        = last;
    tick.src         = (emit_col == source_col) && (emit_row == source_row);
    tick.left_edge   = (emit_col == '0);
    tick.right_edge  = ecol_end;
    tick.top_edge    = (emit_row == '0);
    tick.bottom_edge = erow_end;
    tick.col         = in_col;
    tick.ecol        = emit_col;
    tick.erow        = emit_row;
    tick.temp        = complete ? '0 : cell_temp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= hsten_pkg::RST_GRID_WIDTH;
      grid_height <= hsten_pkg::RST_GRID_HEIGHT;
      source_col  <= hsten_pkg::RST_SOURCE_COL;
      source_row  <= hsten_pkg::RST_SOURCE_ROW;
      gain        <= hsten_pkg::RST_GAIN;
      in_col      <= '0;
      in_row      <= '0;
      emit_col    <= '0;
      emit_row    <= '0;
    end else begin
      if (load) begin
        if (emit && !last) begin
          if (ecol_end) begin
            emit_col <= '0;
            emit_row <= emit_row + 1'b1;
          end else begin
            emit_col <= emit_col + 1'b1;
          end
        end
        if (last) begin
          in_col   <= '0;
          in_row   <= '0;
          emit_col <= '0;
          emit_row <= '0;
        end else if (col_end) begin
          in_col <= '0;
          if (!(complete && (in_row >= hsten_pkg::ROW_W'(2)))) begin
            in_row <= in_row + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end
      if (cfg_valid) begin
        case (cfg_index)
          hsten_pkg::REG_GRID_WIDTH: begin
            grid_width <= cfg_data[hsten_pkg::GWIDTH_W-1:0];
            in_col     <= '0;
            in_row     <= '0;
            emit_col   <= '0;
            emit_row   <= '0;
          end
          hsten_pkg::REG_GRID_HEIGHT: begin
            grid_height <= cfg_data[hsten_pkg::ROW_W-1:0];
            in_col      <= '0;
            in_row      <= '0;
            emit_col    <= '0;
            emit_row    <= '0;
          end
          hsten_pkg::REG_SOURCE_COL: begin
            source_col <= cfg_data[hsten_pkg::COL_W-1:0];
          end
          hsten_pkg::REG_SOURCE_ROW: begin
            source_row <= cfg_data[hsten_pkg::ROW_W-1:0];
          end
          hsten_pkg::REG_GAIN: begin
            gain <= cfg_data[hsten_pkg::GAIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/hsten_window.sv
module hsten_window (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             load,
  input  hsten_pkg::tick_t tick,
  output logic             emit_valid,
  output hsten_pkg::emit_t emit_data
);

  logic                            s1_valid;
  hsten_pkg::tick_t                s1;
  logic                            wr_en;
  logic [hsten_pkg::TEMP_W-1:0]    a_q;
  logic [hsten_pkg::TEMP_W-1:0]    b_q;
  logic [hsten_pkg::TEMP_W-1:0]    a_cur;
  logic [hsten_pkg::TEMP_W-1:0]    b_cur;
  logic                            fwd;
  logic [hsten_pkg::TEMP_W-1:0]    fwd_a;
  logic [hsten_pkg::TEMP_W-1:0]    fwd_b;

  logic [hsten_pkg::TEMP_W-1:0]    prev_x;
  logic [hsten_pkg::TEMP_W-1:0]    a1;
  logic [hsten_pkg::TEMP_W-1:0]    a2;
  logic [hsten_pkg::TEMP_W-1:0]    win0;

  logic [hsten_pkg::TEMP_W-1:0]    tc;
  logic [hsten_pkg::TEMP_W-1:0]    tl;
  logic [hsten_pkg::TEMP_W-1:0]    tr;
  logic [hsten_pkg::TEMP_W-1:0]    tu;
  logic [hsten_pkg::TEMP_W-1:0]    td;
  logic [hsten_pkg::TEMP_W+1:0]    nsum;
  logic signed [hsten_pkg::SUM_W-1:0] diff;

  assign wr_en = s1_valid && s1.shift && advance;

  // The center buffer holds the previous row, the upper buffer the row before it.
  hsten_ram #(.WIDTH(hsten_pkg::TEMP_W), .DEPTH(hsten_pkg::MAX_WIDTH)) u_center (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.col),
    .wdata (s1.temp),
    .re    (load),
    .raddr (tick.col),
    .rdata (a_q)
  );

  hsten_ram #(.WIDTH(hsten_pkg::TEMP_W), .DEPTH(hsten_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.col),
    .wdata (a_cur),
    .re    (load),
    .raddr (tick.col),
    .rdata (b_q)
  );

  assign a_cur = fwd ? fwd_a : a_q;
  assign b_cur = fwd ? fwd_b : b_q;

  always_comb begin
    tc   = a1;
    tl   = s1.left_edge   ? tc : a2;
    tr   = s1.right_edge  ? tc : a_cur;
    tu   = s1.top_edge    ? tc : win0;
    td   = s1.bottom_edge ? tc : prev_x;
    nsum = {2'b00, tl} + {2'b00, tr} + {2'b00, tu} + {2'b00, td};
    diff = $signed({1'b0, nsum}) - $signed({1'b0, tc, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      emit_valid <= 1'b0;
      fwd        <= 1'b0;
    end else if (advance) begin
      s1_valid   <= load;
      emit_valid <= s1_valid && s1.emit;
      if (load) begin
        // A read of the column being written this cycle returns the new data.
        fwd <= s1_valid && s1.shift && (s1.col == tick.col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1             <= tick;
      emit_data.sum  <= diff;
      emit_data.tc   <= tc;
      emit_data.src  <= s1.src;
      emit_data.ecol <= s1.ecol;
      emit_data.erow <= s1.erow;
      emit_data.last <= s1.last;
      if (load) begin
        fwd_a <= s1.temp;
        fwd_b <= a_cur;
      end
      if (s1_valid && s1.shift) begin
        prev_x <= s1.temp;
        a1     <= a_cur;
        a2     <= a1;
        win0   <= b_cur;
      end
    end
  end

endmodule

>>> rtl/hsten_arith.sv
module hsten_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          emit_valid,
  input  hsten_pkg::emit_t              emit_data,
  input  logic [hsten_pkg::GAIN_W-1:0]  gain,
  output logic                          out_valid,
  output logic [hsten_pkg::TEMP_W-1:0]  new_temp,
  output logic [hsten_pkg::COL_W-1:0]   out_col,
  output logic [hsten_pkg::ROW_W-1:0]   out_row,
  output logic                          frame_last
);

  logic                                 s3_valid;
  logic signed [hsten_pkg::PROD_W-1:0]  s3_prod;
  logic [hsten_pkg::TEMP_W-1:0]         s3_tc;
  logic                                 s3_src;
  logic [hsten_pkg::COL_W-1:0]          s3_col;
  logic [hsten_pkg::ROW_W-1:0]          s3_row;
  logic                                 s3_last;

  logic signed [hsten_pkg::PROD_W-1:0]  prod_next;
  logic signed [hsten_pkg::PROD_W-1:0]  rnd;
  logic signed [hsten_pkg::SUM_W-1:0]   q;
  logic signed [hsten_pkg::SUM_W:0]     r;
  logic [hsten_pkg::TEMP_W-1:0]         sat;
  logic [hsten_pkg::TEMP_W-1:0]         temp_next;

  assign prod_next = emit_data.sum * $signed({1'b0, gain});

  always_comb begin
    rnd = s3_prod + hsten_pkg::ROUND_BIAS;
    q   = rnd[hsten_pkg::PROD_W-1:hsten_pkg::FRAC_SHIFT];
    r   = $signed({{(hsten_pkg::SUM_W + 1 - hsten_pkg::TEMP_W){1'b0}}, s3_tc}) +
          $signed({q[hsten_pkg::SUM_W-1], q});
    if (r[hsten_pkg::SUM_W]) begin
      sat = '0;
    end else if (r[hsten_pkg::SUM_W-1:hsten_pkg::TEMP_W] != '0) begin
      sat = '1;
    end else begin
      sat = r[hsten_pkg::TEMP_W-1:0];
    end
    temp_next = s3_src ? s3_tc : sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s3_valid  <= emit_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_prod <= prod_next;
      s3_tc   <= emit_data.tc;
      s3_src  <= emit_data.src;
      s3_col  <= emit_data.ecol;
      s3_row  <= emit_data.erow;
      s3_last <= emit_data.last;
      if (s3_valid) begin
        new_temp   <= temp_next;
        out_col    <= s3_col;
        out_row    <= s3_row;
        frame_last <= s3_last;
      end
    end
  end

endmodule

>>> rtl/heat_stencil_2d_step.sv
// Channel   | Direction | Handshake                  | Payload
// cell      | in        | cell_valid / cell_stall    | action, cell_temp
// result    | out       | result_valid / result_stall| new_temp, out_col, out_row, frame_last
// cfg       | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One cell request is taken per cycle while no result is stalled. A result passes the s1,
// emit_data and s3 registers and leaves the output register after the request completing
// its lower neighbour, width plus one requests after the cell itself. Each request makes one
// pass through the line buffer read, neighbour sum, gain multiplier and round/saturate stage.
// Synchronous reset clears the pipeline and position counters and presets the registers.
// The whole pipeline holds while a result is stalled, and only then is cell_stall high.
module heat_stencil_2d_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cell_valid,
  output logic                          cell_stall,
  input  logic                          action,
  input  logic [hsten_pkg::TEMP_W-1:0]  cell_temp,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [hsten_pkg::TEMP_W-1:0]  new_temp,
  output logic [hsten_pkg::COL_W-1:0]   out_col,
  output logic [hsten_pkg::ROW_W-1:0]   out_row,
  output logic                          frame_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hsten_pkg::IDX_W-1:0]   cfg_index,
  input  logic [hsten_pkg::CFG_W-1:0]   cfg_data
);

  logic                         advance;
  logic                         accept;
  logic                         load;
  hsten_pkg::tick_t             tick;
  logic [hsten_pkg::GAIN_W-1:0] gain;
  logic                         emit_valid;
  hsten_pkg::emit_t             emit_data;

  assign advance    = !result_valid || !result_stall;
  assign cell_stall = !advance;
  assign accept     = cell_valid && advance;
  assign cfg_ready  = 1'b1;

  hsten_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .action    (action),
    .cell_temp (cell_temp),
    .load      (load),
    .tick      (tick),
    .gain      (gain)
  );

  hsten_window u_window (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .load       (load),
    .tick       (tick),
    .emit_valid (emit_valid),
    .emit_data  (emit_data)
  );

  hsten_arith u_arith (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .emit_valid (emit_valid),
    .emit_data  (emit_data),
    .gain       (gain),
    .out_valid  (result_valid),
    .new_temp   (new_temp),
    .out_col    (out_col),
    .out_row    (out_row),
    .frame_last (frame_last)
  );

endmodule

>>> rtl/hsten_checker.sv
module hsten_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cell_valid,
  input logic                          cell_stall,
  input logic                          action,
  input logic [hsten_pkg::TEMP_W-1:0]  cell_temp,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [hsten_pkg::TEMP_W-1:0]  new_temp,
  input logic [hsten_pkg::COL_W-1:0]   out_col,
  input logic [hsten_pkg::ROW_W-1:0]   out_row,
  input logic                          frame_last,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [hsten_pkg::IDX_W-1:0]   cfg_index,
  input logic [hsten_pkg::CFG_W-1:0]   cfg_data
);

  // Input back-pressure only comes from a result waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cell_stall |-> (result_valid && result_stall))
    else $error("cell_stall raised without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid set right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      ($stable(new_temp) && $stable(out_col) && $stable(out_row) && $stable(frame_last)))
    else $error("stalled result payload changed");

endmodule

bind heat_stencil_2d_step hsten_checker u_checker (.*);
